FILE: design/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define SPP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spp assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define SPP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spp assertion failed");

`endif

FILE: design/spp_pkg.sv
package spp_pkg;

  localparam int FLOW_ID_W = 6;
  localparam int WGT_W     = 16;
  localparam int PID_W     = 16;
  localparam int RANK_W    = 32;
  localparam int WIN_W     = 31;
  localparam int ST_W      = 3;
  localparam int QIDX_W    = 3;
  localparam int BOUND_W   = 33;

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(1024);

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_ENQUEUED  = 3'd0,
    ST_DROP_FAR  = 3'd1,
    ST_DROP_FULL = 3'd2,
    ST_DEQUEUED  = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_ENQ,
    S_DEQ,
    S_DEQ_OUT
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic capture;
    logic look;
    logic enq_commit;
    logic deq_pop;
    logic deq_commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic out_free;
  } ctrl_stat_t;

endpackage

FILE: design/spp_if.sv
// Input channel: one beat is one enqueue or dequeue request
interface spp_in_if;
  import spp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 operation;
  logic [FLOW_ID_W-1:0] flow_id;
  logic [WGT_W-1:0]     flow_weight;
  logic [PID_W-1:0]     packet_id;
  modport source (output valid, operation, flow_id, flow_weight, packet_id, input ready);
  modport sink   (input valid, operation, flow_id, flow_weight, packet_id, output ready);
endinterface

// Result channel: one beat per request
interface spp_out_if;
  import spp_pkg::*;
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [QIDX_W-1:0] queue_index;
  logic [PID_W-1:0]  out_packet_id;
  logic [RANK_W-1:0] out_rank;
  modport source (output valid, status, queue_index, out_packet_id, out_rank, input ready);
  modport sink   (input valid, status, queue_index, out_packet_id, out_rank, output ready);
endinterface

// Configuration write channel: rank window register
interface spp_cfg_if;
  import spp_pkg::*;
  logic             valid;
  logic             ready;
  logic [WIN_W-1:0] rank_window;
  modport source (output valid, rank_window, input ready);
  modport sink   (input valid, rank_window, output ready);
endinterface

FILE: design/spp_ctrl.sv
module spp_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_op,
  output logic                   in_ready,
  output spp_pkg::ctrl_cmd_t     cmd,
  input  spp_pkg::ctrl_stat_t    stat
);
  import spp_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (stat.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = (in_op == OP_DEQ) ? S_DEQ : S_LOOK;
      end
      S_LOOK: begin
        state_nxt = S_ENQ;
      end
      S_ENQ: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      S_DEQ: begin
        state_nxt = S_DEQ_OUT;
      end
      S_DEQ_OUT: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
      end
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_LOOK: begin
        cmd.look = 1'b1;
      end
      S_ENQ: begin
        cmd.enq_commit = stat.out_free;
      end
      S_DEQ: begin
        cmd.deq_pop = 1'b1;
      end
      S_DEQ_OUT: begin
        cmd.deq_commit = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: design/spp_dp.sv
module spp_dp #(
  parameter int NUM_QUEUES  = 8,
  parameter int QUEUE_DEPTH = 64,
  parameter int NUM_FLOWS   = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  spp_pkg::ctrl_cmd_t              cmd,
  output spp_pkg::ctrl_stat_t             stat,
  input  logic [spp_pkg::FLOW_ID_W-1:0]   in_flow_id,
  input  logic [spp_pkg::WGT_W-1:0]       in_flow_weight,
  input  logic [spp_pkg::PID_W-1:0]       in_packet_id,
  input  logic                            cfg_we,
  input  logic [spp_pkg::WIN_W-1:0]       cfg_rank_window,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [spp_pkg::ST_W-1:0]        out_status,
  output logic [spp_pkg::QIDX_W-1:0]      out_queue_index,
  output logic [spp_pkg::PID_W-1:0]       out_packet_id,
  output logic [spp_pkg::RANK_W-1:0]      out_rank
);
  import spp_pkg::*;

  localparam int QW       = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int HW       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW       = $clog2(QUEUE_DEPTH + 1);
  localparam int FW       = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;
  localparam int SLOTS    = NUM_QUEUES * QUEUE_DEPTH;
  localparam int AW       = $clog2(SLOTS);
  localparam int FLOW_IDS = 2 ** FLOW_ID_W;
  localparam int EW       = PID_W + RANK_W;

  localparam logic signed [BOUND_W+1:0] BMIN_EXT = -35'sd4294967296;
  localparam logic signed [BOUND_W-1:0] BMIN     = BMIN_EXT[BOUND_W-1:0];

  // flow id folded onto the table depth, worked out at elaboration
  logic [FW-1:0] flow_map [FLOW_IDS];
  for (genvar g = 0; g < FLOW_IDS; g++) begin : g_flow_map
    assign flow_map[g] = FW'(g % NUM_FLOWS);
  end

  // state
  logic [WIN_W-1:0]          window_r;
  logic [RANK_W-1:0]         round_r;
  logic signed [BOUND_W-1:0] bound_r [NUM_QUEUES];
  logic [HW-1:0]             head_r  [NUM_QUEUES];
  logic [HW-1:0]             tail_r  [NUM_QUEUES];
  logic [CW-1:0]             count_r [NUM_QUEUES];
  logic [FW-1:0]             clr_cnt_r;

  logic [RANK_W-1:0] lf_mem [NUM_FLOWS];
  logic [RANK_W-1:0] lf_rd_r;
  logic [EW-1:0]     st_mem [SLOTS];
  logic [EW-1:0]     st_rd_r;

  logic [FW-1:0]     flow_r;
  logic [WGT_W-1:0]  weight_r;
  logic [PID_W-1:0]  pid_r;
  logic [RANK_W-1:0] rank_r;
  logic [RANK_W-1:0] fin_r;
  logic              far_r;
  logic [QW-1:0]     deq_q_r;
  logic              deq_any_r;

  logic              out_valid_r;
  status_t           out_status_r;
  logic [QIDX_W-1:0] out_qidx_r;
  logic [PID_W-1:0]  out_pid_r;
  logic [RANK_W-1:0] out_rank_r;

  // status to controller
  assign stat.out_free = !out_valid_r || out_ready;
  assign stat.clr_done = (clr_cnt_r == FW'(NUM_FLOWS - 1));

  // rank, window check and finish round
  logic [RANK_W-1:0] rank_c;
  logic [RANK_W-1:0] diff_c;
  logic [RANK_W:0]   fin_sum;
  always_comb begin
    rank_c  = (lf_rd_r > round_r) ? lf_rd_r : round_r;
    diff_c  = rank_c - round_r;
    fin_sum = {1'b0, rank_c} + (RANK_W+1)'(weight_r);
  end

  // bound scan: highest queue whose bound is at most the rank
  logic signed [BOUND_W-1:0] rank_s;
  logic [QW-1:0]             sel_q;
  logic                      hit_any;
  logic                      full_c;
  logic signed [BOUND_W+1:0] gap_c;
  logic signed [BOUND_W-1:0] low_b [NUM_QUEUES];
  always_comb begin
    logic signed [BOUND_W+1:0] nb;
    rank_s  = $signed({1'b0, rank_r});
    sel_q   = '0;
    hit_any = 1'b0;
    for (int q = 0; q < NUM_QUEUES; q++) begin
      if (rank_s >= bound_r[q]) begin
        sel_q   = QW'(q);
        hit_any = 1'b1;
      end
    end
    full_c = (count_r[sel_q] == CW'(QUEUE_DEPTH));
    gap_c  = $signed({{2{bound_r[0][BOUND_W-1]}}, bound_r[0]}) - $signed({3'b000, rank_r});
    for (int q = 0; q < NUM_QUEUES; q++) begin
      nb       = $signed({{2{bound_r[q][BOUND_W-1]}}, bound_r[q]}) - gap_c;
      low_b[q] = (nb < BMIN_EXT) ? BMIN : nb[BOUND_W-1:0];
    end
  end

  // lowest non-empty queue
  logic [QW-1:0] deq_q;
  logic          deq_any;
  always_comb begin
    deq_q   = '0;
    deq_any = 1'b0;
    for (int q = NUM_QUEUES - 1; q >= 0; q--) begin
      if (count_r[q] != '0) begin
        deq_q   = QW'(q);
        deq_any = 1'b1;
      end
    end
  end

  logic          push;
  logic          pop;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  assign push    = cmd.enq_commit && !far_r && !full_c;
  assign pop     = cmd.deq_pop && deq_any;
  assign wr_addr = AW'(sel_q) * AW'(QUEUE_DEPTH) + AW'(tail_r[sel_q]);
  assign rd_addr = AW'(deq_q) * AW'(QUEUE_DEPTH) + AW'(head_r[deq_q]);

  // per-flow finish table: cleared by a sweep after reset
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      lf_mem[clr_cnt_r] <= '0;
    end else if (cmd.enq_commit && !far_r) begin
      lf_mem[flow_r] <= fin_r;
    end
    if (cmd.capture) lf_rd_r <= lf_mem[flow_map[in_flow_id]];
  end

  // FIFO entry store
  always_ff @(posedge clk) begin
    if (push) st_mem[wr_addr] <= {pid_r, rank_r};
    if (cmd.deq_pop) st_rd_r <= st_mem[rd_addr];
  end

  // sweep counter, window, round
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      window_r  <= WINDOW_RESET;
      round_r   <= '0;
    end else begin
      if (cmd.clr_step && !stat.clr_done) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cfg_we) window_r <= cfg_rank_window;
      if (cmd.deq_commit && deq_any_r) round_r <= st_rd_r[RANK_W-1:0];
    end
  end

  // bounds and FIFO pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
        bound_r[q] <= '0;
        head_r[q]  <= '0;
        tail_r[q]  <= '0;
        count_r[q] <= '0;
      end
    end else begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
        if (push && sel_q == QW'(q)) begin
          tail_r[q]  <= (tail_r[q] == HW'(QUEUE_DEPTH - 1)) ? '0 : tail_r[q] + 1'b1;
          count_r[q] <= count_r[q] + 1'b1;
        end
        if (pop && deq_q == QW'(q)) begin
          head_r[q]  <= (head_r[q] == HW'(QUEUE_DEPTH - 1)) ? '0 : head_r[q] + 1'b1;
          count_r[q] <= count_r[q] - 1'b1;
        end
        if (push) begin
          if (hit_any) begin
            if (sel_q == QW'(q)) bound_r[q] <= rank_s;
          end else if (q == 0) begin
            bound_r[q] <= rank_s;
          end else begin
            bound_r[q] <= low_b[q];
          end
        end
      end
    end
  end

  // request capture and enqueue arithmetic
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      flow_r   <= flow_map[in_flow_id];
      weight_r <= in_flow_weight;
      pid_r    <= in_packet_id;
    end
    if (cmd.look) begin
      rank_r <= rank_c;
      far_r  <= (diff_c > {1'b0, window_r});
      fin_r  <= fin_sum[RANK_W] ? '1 : fin_sum[RANK_W-1:0];
    end
    if (cmd.deq_pop) begin
      deq_q_r   <= deq_q;
      deq_any_r <= deq_any;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.enq_commit || cmd.deq_commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.enq_commit) begin
      out_pid_r  <= pid_r;
      out_rank_r <= rank_r;
      if (far_r) begin
        out_status_r <= ST_DROP_FAR;
        out_qidx_r   <= '0;
      end else begin
        out_status_r <= full_c ? ST_DROP_FULL : ST_ENQUEUED;
        out_qidx_r   <= QIDX_W'(sel_q);
      end
    end else if (cmd.deq_commit) begin
      if (deq_any_r) begin
        out_status_r <= ST_DEQUEUED;
        out_qidx_r   <= QIDX_W'(deq_q_r);
        out_pid_r    <= st_rd_r[EW-1:RANK_W];
        out_rank_r   <= st_rd_r[RANK_W-1:0];
      end else begin
        out_status_r <= ST_EMPTY;
        out_qidx_r   <= '0;
        out_pid_r    <= '0;
        out_rank_r   <= '0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_queue_index = out_qidx_r;
  assign out_packet_id   = out_pid_r;
  assign out_rank        = out_rank_r;

endmodule

FILE: design/sp_pifo_scheduler.sv
// Enqueue steps through S_IDLE, S_LOOK and S_ENQ, dequeue through S_IDLE, S_DEQ and
// S_DEQ_OUT; one request is in flight at a time, so the next is taken only in S_IDLE.
// S_LOOK and S_DEQ cover the registered read of the per-flow finish memory (enqueue)
// and of the FIFO entry memory (dequeue). A result held by the sink stalls the commit.
// After rst_n the per-flow finish memory is swept to zero, one entry a cycle, over all
// NUM_FLOWS entries with in_beat.ready low; configuration writes are taken throughout.
module sp_pifo_scheduler #(
  parameter int NUM_QUEUES  = 8,
  parameter int QUEUE_DEPTH = 64,
  parameter int NUM_FLOWS   = 64
) (
  input logic       clk,
  input logic       rst_n,
  spp_in_if.sink    in_beat,
  spp_out_if.source out_beat,
  spp_cfg_if.sink   cfg_beat
);
  import spp_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  // configuration always taken
  assign cfg_beat.ready = 1'b1;

  spp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_beat.valid),
    .in_op    (in_beat.operation),
    .in_ready (in_beat.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  spp_dp #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .NUM_FLOWS   (NUM_FLOWS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_flow_id      (in_beat.flow_id),
    .in_flow_weight  (in_beat.flow_weight),
    .in_packet_id    (in_beat.packet_id),
    .cfg_we          (cfg_beat.valid && cfg_beat.ready),
    .cfg_rank_window (cfg_beat.rank_window),
    .out_valid       (out_beat.valid),
    .out_ready       (out_beat.ready),
    .out_status      (out_beat.status),
    .out_queue_index (out_beat.queue_index),
    .out_packet_id   (out_beat.out_packet_id),
    .out_rank        (out_beat.out_rank)
  );

endmodule

FILE: design/spp_checker.sv
`include "assert_macros.svh"

module spp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [spp_pkg::ST_W-1:0]      out_status,
  input logic [spp_pkg::QIDX_W-1:0]    out_queue_index,
  input logic [spp_pkg::PID_W-1:0]     out_packet_id,
  input logic [spp_pkg::RANK_W-1:0]    out_rank
);
  import spp_pkg::*;

  logic in_acc;
  logic out_stall;
  logic empty_beat;
  logic fields_zero;
  assign in_acc      = in_valid && in_ready;
  assign out_stall   = out_valid && !out_ready;
  assign empty_beat  = out_valid && (out_status == ST_EMPTY);
  assign fields_zero = (out_queue_index == '0) && (out_packet_id == '0) && (out_rank == '0);

  // a stalled result beat stays up with the same handle
  `SPP_ASSERT_NEXT(a_out_hold, out_stall, out_valid)
  `SPP_ASSERT_NEXT(a_out_pid_hold, out_stall, $stable(out_packet_id))
  // empty dequeue carries zero fields
  `SPP_ASSERT_IMPL(a_empty_zero, empty_beat, fields_zero)
  // no result beat appears in the cycle straight after a request
  `SPP_ASSERT_NEXT(a_no_early_result, in_acc, !$rose(out_valid))

endmodule

bind sp_pifo_scheduler spp_checker u_spp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_beat.valid),
  .in_ready        (in_beat.ready),
  .out_valid       (out_beat.valid),
  .out_ready       (out_beat.ready),
  .out_status      (out_beat.status),
  .out_queue_index (out_beat.queue_index),
  .out_packet_id   (out_beat.out_packet_id),
  .out_rank        (out_beat.out_rank)
);

FILE: tb/sv/tb.sv
module tb;
  import spp_pkg::*;

  localparam int NQ        = 8;
  localparam int QDEPTH    = 64;
  localparam int NFLOWS    = 64;
  localparam int N_RANDOM  = 800;
  localparam int MAX_CYC   = 400000;
  localparam logic signed [BOUND_W:0] BOUND_FLOOR = -(34'sd1 <<< 32);

  // One directed row; chk set where the result is typed in
  typedef struct {
    op_t                  op;
    logic [FLOW_ID_W-1:0] flow;
    logic [WGT_W-1:0]     wgt;
    logic [PID_W-1:0]     pid;
    logic                 chk;
    status_t              st;
    logic [QIDX_W-1:0]    qi;
    logic [RANK_W-1:0]    rk;
  } dir_row_t;

  typedef struct packed {
    status_t           st;
    logic [QIDX_W-1:0] qi;
    logic [PID_W-1:0]  pid;
    logic [RANK_W-1:0] rk;
  } sched_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  spp_in_if  in_ch ();
  spp_out_if out_ch ();
  spp_cfg_if cfg_ch ();

  sp_pifo_scheduler #(.NUM_QUEUES(NQ), .QUEUE_DEPTH(QDEPTH), .NUM_FLOWS(NFLOWS)) uut (
    .clk(clk), .rst_n(rst_n), .in_beat(in_ch.sink), .out_beat(out_ch.source),
    .cfg_beat(cfg_ch.sink)
  );

  // Predictor state
  logic [WIN_W-1:0]         p_window;
  logic [RANK_W-1:0]        p_finish [NFLOWS];
  logic signed [BOUND_W:0]  p_bound [NQ];
  logic [RANK_W-1:0]        p_round;
  sched_res_t               p_fifo [NQ][$];

  sched_res_t exp_results [$];
  int errors = 0;
  int cycles = 0;
  bit sink_hold = 1'b0;
  bit sink_calm = 1'b0;
  bit src_calm = 1'b0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic sched_res_t predict_schedule(input op_t op, input logic [FLOW_ID_W-1:0] fl,
                                                  input logic [WGT_W-1:0] w,
                                                  input logic [PID_W-1:0] pid);
    sched_res_t r;
    logic [RANK_W-1:0] rank;
    logic [RANK_W:0] fin;
    logic signed [BOUND_W:0] gap, nb;
    int f;
    f = fl % NFLOWS;
    if (op == OP_DEQ) begin
      for (int q = 0; q < NQ; q++) begin
        if (p_fifo[q].size() > 0) begin
          r = p_fifo[q].pop_front();
          p_round = r.rk;
          r.st = ST_DEQUEUED;
          r.qi = QIDX_W'(q);
          return r;
        end
      end
      r = '{ST_EMPTY, '0, '0, '0};
      return r;
    end
    rank = (p_finish[f] > p_round) ? p_finish[f] : p_round;
    r = '{ST_ENQUEUED, '0, pid, rank};
    if (rank - p_round > {1'b0, p_window}) begin
      r.st = ST_DROP_FAR;
      return r;
    end
    fin = rank + w;
    p_finish[f] = fin[RANK_W] ? '1 : fin[RANK_W-1:0];
    // push-up: highest queue whose bound is at most the rank
    for (int q = NQ - 1; q >= 0; q--) begin
      if ($signed({2'b00, rank}) >= p_bound[q]) begin
        r.qi = QIDX_W'(q);
        if (p_fifo[q].size() >= QDEPTH) begin
          r.st = ST_DROP_FULL;
        end else begin
          p_fifo[q] = {p_fifo[q], r};
          p_bound[q] = $signed({2'b00, rank});
        end
        return r;
      end
    end
    // push-down into queue 0, lowering every other bound
    if (p_fifo[0].size() >= QDEPTH) begin
      r.st = ST_DROP_FULL;
      return r;
    end
    p_fifo[0] = {p_fifo[0], r};
    gap = p_bound[0] - $signed({2'b00, rank});
    p_bound[0] = $signed({2'b00, rank});
    for (int q = 1; q < NQ; q++) begin
      nb = p_bound[q] - gap;
      p_bound[q] = (nb < BOUND_FLOOR) ? BOUND_FLOOR : nb;
    end
    return r;
  endfunction

  // Cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYC) begin
      $display("timeout at cycle %0d", cycles);
      $display("sp_pifo_scheduler verification failed");
      $finish;
    end
  end

  // Result sink: random stall, long hold and calm stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !sink_hold && (sink_calm || $urandom_range(99) >= 14);
      if (out_ch.valid && out_ch.ready) begin
        if (exp_results.size() == 0) begin
          report("unexpected beat", out_ch.status, 0);
        end else begin
          sched_res_t e;
          e = exp_results.pop_front();
          if (out_ch.status !== e.st) report("status", out_ch.status, e.st);
          if (out_ch.queue_index !== e.qi) report("queue_index", out_ch.queue_index, e.qi);
          if (out_ch.out_packet_id !== e.pid) report("packet_id", out_ch.out_packet_id, e.pid);
          if (out_ch.out_rank !== e.rk) report("rank", out_ch.out_rank, e.rk);
        end
      end
    end
  end

  // Long receiver hold-off, counted in cycles, while the sender keeps offering
  initial begin
    wait (cycles == 1500);
    sink_hold = 1'b1;
    repeat (400) @(posedge clk);
    sink_hold = 1'b0;
  end

  // valid stays up from one accepted beat to the next unless the sender idles
  task automatic send_item(input op_t op, input logic [FLOW_ID_W-1:0] fl,
                           input logic [WGT_W-1:0] w, input logic [PID_W-1:0] pid,
                           input bit chk, input sched_res_t typed);
    sched_res_t r;
    while (!src_calm && $urandom_range(99) < 14) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.flow_id <= fl;
    in_ch.flow_weight <= w;
    in_ch.packet_id <= pid;
    do @(posedge clk); while (!in_ch.ready);
    r = predict_schedule(op, fl, w, pid);
    if (chk && (r != typed)) report("typed row", {r.st, r.qi, r.pid}, {typed.st, typed.qi, typed.pid});
    exp_results = {exp_results, r};
  endtask

  task automatic drain;
    int lim;
    lim = 0;
    in_ch.valid <= 1'b0;
    while (exp_results.size() != 0 && lim < 100000) begin
      @(posedge clk);
      lim++;
    end
    repeat (10) @(posedge clk);
  endtask

  task automatic write_window(input logic [WIN_W-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.rank_window <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    p_window = v;
  endtask

  dir_row_t dir_rows [12] = '{
    '{OP_DEQ, 6'd0,  16'd0,     16'd0,     1'b1, ST_EMPTY,    3'd0, 32'd0},
    '{OP_ENQ, 6'd0,  16'd0,     16'd0,     1'b1, ST_ENQUEUED, 3'd7, 32'd0},
    '{OP_ENQ, 6'd63, 16'hFFFF, 16'hFFFF,   1'b1, ST_ENQUEUED, 3'd7, 32'd0},
    '{OP_ENQ, 6'd63, 16'd5,    16'h1234,   1'b1, ST_DROP_FAR, 3'd0, 32'hFFFF},
    '{OP_ENQ, 6'd1,  16'd1000, 16'hA5A5,   1'b0, ST_ENQUEUED, 3'd0, 32'd0},
    '{OP_ENQ, 6'd1,  16'd1,    16'h5A5A,   1'b0, ST_ENQUEUED, 3'd0, 32'd0},
    '{OP_DEQ, 6'd0,  16'd0,    16'd0,      1'b0, ST_ENQUEUED, 3'd0, 32'd0},
    '{OP_DEQ, 6'd0,  16'd0,    16'd0,      1'b0, ST_ENQUEUED, 3'd0, 32'd0},
    '{OP_ENQ, 6'd2,  16'd7,    16'd77,     1'b0, ST_ENQUEUED, 3'd0, 32'd0},
    '{OP_DEQ, 6'd0,  16'd0,    16'd0,      1'b0, ST_ENQUEUED, 3'd0, 32'd0},
    '{OP_DEQ, 6'd0,  16'd0,    16'd0,      1'b0, ST_ENQUEUED, 3'd0, 32'd0},
    '{OP_DEQ, 6'd0,  16'd0,    16'd0,      1'b0, ST_ENQUEUED, 3'd0, 32'd0}
  };

  initial begin
    sched_res_t typed;
    int sent;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_ENQ;
    in_ch.flow_id = '0;
    in_ch.flow_weight = '0;
    in_ch.packet_id = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.rank_window = '0;
    p_window = WINDOW_RESET;
    p_round = '0;
    foreach (p_finish[i]) p_finish[i] = '0;
    foreach (p_bound[i]) p_bound[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    foreach (dir_rows[i]) begin
      typed = '{dir_rows[i].st, dir_rows[i].qi, dir_rows[i].pid, dir_rows[i].rk};
      if (dir_rows[i].st == ST_EMPTY) typed.pid = '0;
      send_item(dir_rows[i].op, dir_rows[i].flow, dir_rows[i].wgt, dir_rows[i].pid,
                dir_rows[i].chk, typed);
    end
    drain();

    // Fill queue 7 with a zero-weight flow to reach the full case
    for (int k = 0; k < QDEPTH + 3; k++)
      send_item(OP_ENQ, 6'd9, 16'd0, k[PID_W-1:0], 1'b0, typed);
    drain();

    // Random phases across window settings, extremes included
    sent = 0;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_window('0);
        1: write_window('1);
        2: write_window(WIN_W'(200));
        3: write_window(WIN_W'($urandom_range(70000)));
        default: write_window(WIN_W'(4096));
      endcase
      // one phase runs with no idling on either side
      src_calm = (ph == 2);
      sink_calm = (ph == 2);
      for (int k = 0; k < N_RANDOM / 5; k++) begin
        op_t op;
        logic [WGT_W-1:0] w;
        op = ($urandom_range(99) < 45) ? OP_DEQ : OP_ENQ;
        case ($urandom_range(3))
          0: w = WGT_W'($urandom);
          1: w = WGT_W'($urandom_range(3));
          default: w = WGT_W'($urandom_range(300));
        endcase
        send_item(op, FLOW_ID_W'($urandom), w, PID_W'($urandom), 1'b0, typed);
        sent++;
      end
      src_calm = 1'b0;
      sink_calm = 1'b0;
      // pause until every expected beat is back
      drain();
    end

    drain();
    if (errors == 0) begin
      $display("sp_pifo_scheduler verification clean");
    end else begin
      $display("sp_pifo_scheduler verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/spp_pkg.sv
design/spp_if.sv
design/spp_ctrl.sv
design/spp_dp.sv
design/sp_pifo_scheduler.sv
design/spp_checker.sv
tb/sv/tb.sv
